// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the GF(2) divider RTL.
// Plain text macros, no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GF2PD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("gf2pd: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GF2PD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("gf2pd: assertion failed");

`endif

// ===== rtl/core/gf2pd_pkg.sv =====
// Package for the GF(2) polynomial divider: widths, control types, FSM states.
// No dependencies.
package gf2pd_pkg;

  // Fixed field widths of the item ports
  localparam int unsigned FIELD_W        = 64;
  localparam int unsigned DEG_W          = 6;
  // Default polynomial width and the group size of the top-bit finder
  localparam int unsigned POLY_WIDTH_DEF = 64;
  localparam int unsigned GROUP_W        = 8;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_SCAN,
    S_HOLD
  } gf2pd_state_e;

  // Control shared by every cell of the row
  typedef struct packed {
    logic load;   // take a new item
    logic shift;  // one walk step
    logic fire;   // remainder bit set: xor in the divisor, emit quotient 1
  } gf2pd_cell_ctl_t;

endpackage

// ===== rtl/core/gf2pd_if.sv =====
// Valid/ready channel interfaces for the GF(2) divider items.
// Depends on gf2pd_pkg.
interface gf2pd_in_if import gf2pd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] dividend;
  logic [DEG_W-1:0]   dividend_degree;
  logic [FIELD_W-1:0] divisor;
  logic [DEG_W-1:0]   divisor_degree;

  modport source (output valid, dividend, dividend_degree, divisor, divisor_degree,
                  input ready);
  modport sink   (input valid, dividend, dividend_degree, divisor, divisor_degree,
                  output ready);
endinterface

interface gf2pd_out_if import gf2pd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] quotient;
  logic [DEG_W-1:0]   quotient_degree;
  logic [FIELD_W-1:0] remainder;
  logic [DEG_W-1:0]   remainder_degree;
  logic               divides_evenly;

  modport source (output valid, quotient, quotient_degree, remainder, remainder_degree,
                  divides_evenly, input ready);
  modport sink   (input valid, quotient, quotient_degree, remainder, remainder_degree,
                  divides_evenly, output ready);
endinterface

// ===== rtl/core/gf2_polynomial_divider_unit.sv =====
// GF(2) polynomial divider: one item at a time through a row of POLY_WIDTH bit
// cells. After an input transfer the row walks POLY_WIDTH steps, one shift of
// the divisor per cycle, from shift POLY_WIDTH-1 down to 0; steps outside the
// range from the dividend degree down to the divisor degree change nothing.
// The walk length, set by the cell row, is the same for every item. A top-bit
// search state (S_SCAN) and a state that moves the result into the output
// register (S_HOLD) follow. Input is taken only in S_IDLE, so a new item waits
// until the last one has been moved into the output register, and S_HOLD waits
// for the sink to free that register. The output register lets the next item
// start while a result still waits. Degrees above POLY_WIDTH-1 saturate;
// words are cut to POLY_WIDTH bits.
// Depends on gf2pd_pkg, gf2pd_if, gf2pd_cell, gf2pd_msb_find, assert_macros.svh.
`include "assert_macros.svh"

module gf2_polynomial_divider_unit import gf2pd_pkg::*; #(
  parameter int unsigned POLY_WIDTH = POLY_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gf2pd_in_if.sink    in_i,
  gf2pd_out_if.source out_o
);

  localparam int unsigned W     = POLY_WIDTH;
  localparam int unsigned IDX_W = $clog2(W);
  localparam logic [DEG_W-1:0] MaxDeg = DEG_W'(W - 1);

  gf2pd_state_e    state_q, state_d;
  gf2pd_cell_ctl_t ctl;

  logic [IDX_W-1:0] s_q, s_d;
  logic [IDX_W-1:0] dd_q, dd_d;
  logic [IDX_W-1:0] diff_q, diff_d;
  logic             ge_q, ge_d;
  logic             any_q, any_d;
  logic [IDX_W-1:0] qdeg_q, qdeg_d;

  logic             in_fire, out_load, scan_load;
  logic [IDX_W-1:0] top_c, dd_c, p_c;
  logic             active, fire;

  logic [W-1:0] dividend_m, divisor_m;
  logic [W-1:0] rem_vec, dv_vec, q_vec;
  logic [W-2:0] up_q;

  logic [DEG_W-1:0] rdeg;
  logic             rzero;

  logic             out_valid_q;
  logic [W-1:0]     quo_out_q, rem_out_q;
  logic [DEG_W-1:0] qdeg_out_q, rdeg_out_q;
  logic             even_out_q;

  assign in_fire    = in_i.valid & in_i.ready;
  assign dividend_m = in_i.dividend[W-1:0];
  assign divisor_m  = in_i.divisor[W-1:0];

  // Saturate the stated degrees to the word
  assign top_c = (in_i.dividend_degree > MaxDeg) ? IDX_W'(MaxDeg)
                                                  : in_i.dividend_degree[IDX_W-1:0];
  assign dd_c  = (in_i.divisor_degree > MaxDeg) ? IDX_W'(MaxDeg)
                                                 : in_i.divisor_degree[IDX_W-1:0];

  // Step is live when position s+dd lies between the divisor and dividend degrees
  assign p_c    = s_q + dd_q;
  assign active = ge_q && (s_q <= diff_q);
  assign fire   = (state_q == S_RUN) && active && rem_vec[p_c];

  // Controller
  always_comb begin
    state_d   = state_q;
    ctl       = '0;
    scan_load = 1'b0;
    out_load  = 1'b0;
    s_d       = s_q;
    dd_d      = dd_q;
    diff_d    = diff_q;
    ge_d      = ge_q;
    any_d     = any_q;
    qdeg_d    = qdeg_q;
    in_i.ready = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          ctl.load = 1'b1;
          s_d      = IDX_W'(W - 1);
          dd_d     = dd_c;
          diff_d   = top_c - dd_c;
          ge_d     = (top_c >= dd_c);
          any_d    = 1'b0;
          qdeg_d   = '0;
          state_d  = S_RUN;
        end
      end
      S_RUN: begin
        ctl.shift = 1'b1;
        ctl.fire  = fire;
        if (fire && !any_q) begin
          any_d  = 1'b1;
          qdeg_d = s_q;
        end
        s_d = s_q - 1'b1;
        if (s_q == '0) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        scan_load = 1'b1;
        state_d   = S_HOLD;
      end
      S_HOLD: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      s_q     <= '0;
      dd_q    <= '0;
      diff_q  <= '0;
      ge_q    <= 1'b0;
      any_q   <= 1'b0;
      qdeg_q  <= '0;
    end else begin
      state_q <= state_d;
      s_q     <= s_d;
      dd_q    <= dd_d;
      diff_q  <= diff_d;
      ge_q    <= ge_d;
      any_q   <= any_d;
      qdeg_q  <= qdeg_d;
    end
  end

  // Divisor bits above the row: the word starts at shift POLY_WIDTH-1
  always_ff @(posedge clk_i) begin
    if (ctl.load) begin
      up_q <= divisor_m[W-1:1];
    end else if (ctl.shift) begin
      up_q <= {1'b0, up_q[W-2:1]};
    end
  end

  // Row of bit cells
  for (genvar i = 0; i < W; i++) begin : g_cell
    logic dv_ld, dv_in, q_in;
    if (i == W - 1) begin : g_top
      assign dv_ld = divisor_m[0];
      assign dv_in = up_q[0];
    end else begin : g_mid
      assign dv_ld = 1'b0;
      assign dv_in = dv_vec[i+1];
    end
    if (i == 0) begin : g_low
      assign q_in = fire;
    end else begin : g_up
      assign q_in = q_vec[i-1];
    end
    gf2pd_cell u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .rem_ld_i (dividend_m[i]),
      .dv_ld_i  (dv_ld),
      .dv_i     (dv_in),
      .q_i      (q_in),
      .rem_o    (rem_vec[i]),
      .dv_o     (dv_vec[i]),
      .q_o      (q_vec[i])
    );
  end

  // Remainder degree search
  gf2pd_msb_find #(.W(W)) u_msb (
    .clk_i  (clk_i),
    .load_i (scan_load),
    .vec_i  (rem_vec),
    .deg_o  (rdeg),
    .zero_o (rzero)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      quo_out_q  <= q_vec;
      qdeg_out_q <= DEG_W'(qdeg_q);
      rem_out_q  <= rem_vec;
      rdeg_out_q <= rdeg;
      even_out_q <= rzero;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.quotient         = FIELD_W'(quo_out_q);
  assign out_o.quotient_degree  = qdeg_out_q;
  assign out_o.remainder        = FIELD_W'(rem_out_q);
  assign out_o.remainder_degree = rdeg_out_q;
  assign out_o.divides_evenly   = even_out_q;

  // Checks
  `GF2PD_ASSERT_NXT(a_start_run, clk_i, rst_ni, in_fire, state_q == S_RUN && s_q == IDX_W'(W - 1))
  `GF2PD_ASSERT_IMP(a_even_flag, clk_i, rst_ni, out_valid_q, even_out_q == (rem_out_q == '0))
  `GF2PD_ASSERT_IMP(a_qdeg_bit, clk_i, rst_ni, out_valid_q && (quo_out_q != '0), quo_out_q[qdeg_out_q])
  `GF2PD_ASSERT_IMP(a_no_step, clk_i, rst_ni, state_q == S_RUN && !ge_q, !fire)

endmodule

// ===== rtl/core/gf2pd_cell.sv =====
// One bit cell of the divider row: remainder bit, divisor bit, quotient bit.
// Depends on gf2pd_pkg.
module gf2pd_cell import gf2pd_pkg::*; (
  input  logic            clk_i,
  input  gf2pd_cell_ctl_t ctl_i,
  input  logic            rem_ld_i,  // dividend bit on load
  input  logic            dv_ld_i,   // aligned divisor bit on load
  input  logic            dv_i,      // divisor bit from the cell above
  input  logic            q_i,       // quotient bit from the cell below
  output logic            rem_o,
  output logic            dv_o,
  output logic            q_o
);

  logic rem_q, rem_d;
  logic dv_q, dv_d;
  logic q_q, q_d;

  // Divisor moves down, quotient moves up, remainder stays and takes the xor
  always_comb begin
    rem_d = rem_q;
    dv_d  = dv_q;
    q_d   = q_q;
    if (ctl_i.load) begin
      rem_d = rem_ld_i;
      dv_d  = dv_ld_i;
      q_d   = 1'b0;
    end else if (ctl_i.shift) begin
      rem_d = rem_q ^ (ctl_i.fire & dv_q);
      dv_d  = dv_i;
      q_d   = q_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dv_q  <= dv_d;
    q_q   <= q_d;
  end

  assign rem_o = rem_q;
  assign dv_o  = dv_q;
  assign q_o   = q_q;

endmodule

// ===== rtl/core/gf2pd_msb_find.sv =====
// Two-stage top set bit finder: per-byte encode, then group select.
// Depends on gf2pd_pkg.
module gf2pd_msb_find import gf2pd_pkg::*; #(
  parameter int unsigned W = POLY_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             load_i,
  input  logic [W-1:0]     vec_i,
  output logic [DEG_W-1:0] deg_o,   // 0 when the word is zero
  output logic             zero_o
);

  localparam int unsigned NGRP  = (W + GROUP_W - 1) / GROUP_W;
  localparam int unsigned PAD_W = NGRP * GROUP_W;
  localparam int unsigned LOC_W = $clog2(GROUP_W);

  logic [PAD_W-1:0] pad;
  logic [NGRP-1:0]  grp_any_d, grp_any_q;
  logic [LOC_W-1:0] grp_idx_d [NGRP];
  logic [LOC_W-1:0] grp_idx_q [NGRP];
  logic [DEG_W-1:0] deg_c;

  assign pad = PAD_W'(vec_i);

  // Stage 1: per group, any bit set and the index of the highest one
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_d[g] = |pad[g*GROUP_W +: GROUP_W];
      grp_idx_d[g] = '0;
      for (int b = 0; b < GROUP_W; b++) begin
        if (pad[g*GROUP_W + b]) begin
          grp_idx_d[g] = LOC_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_any_q <= grp_any_d;
      grp_idx_q <= grp_idx_d;
    end
  end

  // Stage 2: highest group that holds a set bit
  always_comb begin
    deg_c = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (grp_any_q[g]) begin
        deg_c = DEG_W'(g * GROUP_W + int'(grp_idx_q[g]));
      end
    end
  end

  assign deg_o  = deg_c;
  assign zero_o = ~|grp_any_q;

endmodule
